FILE: src/esc_pkg.sv
package esc_pkg;

  localparam int AddrWidth = 6;
  localparam int DataWidth = 64;

  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;
  localparam logic [2:0] REG_HUM_A   = 3'd4;
  localparam logic [2:0] REG_HUM_B   = 3'd5;

  localparam logic [1:0] OP_TEMP  = 2'd0;
  localparam logic [1:0] OP_PRESS = 2'd1;
  localparam logic [1:0] OP_HUM   = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [31:0] HumClamp = 32'd419430400;

  typedef struct packed {
    logic [1:0]  operation;
    logic [19:0] raw_sample;
  } sample_t;

  typedef struct packed {
    logic signed [32:0] compensated_value;
    logic               pressure_invalid;
  } result_t;

  typedef struct packed {
    logic [47:0] temp_coeffs;
    logic [47:0] press_coeffs_a;
    logic [47:0] press_coeffs_b;
    logic [47:0] press_coeffs_c;
    logic [31:0] hum_coeffs_a;
    logic [31:0] hum_coeffs_b;
  } coeffs_t;

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] n);
    return 64'($signed(v) >>> n);
  endfunction

  // Wrap to 32 bits, then shift arithmetically.
  function automatic logic [63:0] asr32(input logic [63:0] v, input logic [5:0] n);
    return asr64(sx32(v[31:0]), n);
  endfunction

endpackage

FILE: src/env_sensor_compensation_unit.sv
// Environmental sensor compensation unit.
// Samples enter on the sample channel (valid/ready), each tagged temperature,
// pressure or humidity; one result leaves on the result channel per sample.
// Calibration coefficients are written over the APB port at byte address
// 8*index; the user must write them only while the unit is idle, as the
// block does not enforce it. Reads return the stored values. Work is done by
// one 64-bit radix-16 multiplier (16 iterations) and one restoring divider
// (64 iterations), stepped by a small sequencer. Temperature takes three
// products, pressure ten products plus the division (seven products and no
// division when the divisor is zero) and humidity eight; an unknown
// operation gives a zero result with no arithmetic.
// One sample is in work at a time; sample_ready is high only when the
// sequencer is idle, so a new sample waits until the last one is finished.
// A finished result sits in the output register, and the next sample may be
// accepted while it waits. If the receiver still holds the previous result
// when the next one is finished, the sequencer waits until it is taken.
// Reset clears the coefficients, the stored fine temperature and all
// control state; no result is pending afterward.
module env_sensor_compensation_unit
  import esc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL, S_DIV, S_FIN} state_t;

  coeffs_t coeffs;
  state_t  state;
  logic [3:0]  pc;
  logic [1:0]  op;
  logic [19:0] raw;
  logic [63:0] x, y, z, w, prod;
  logic [31:0] fine_temperature;
  logic        neg;
  logic [32:0] res_value;
  logic        res_bad;

  logic        mul_start, mul_busy, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic        div_start, div_busy, div_done;
  logic [63:0] div_n, div_d, div_q;

  esc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .coeffs
  );

  esc_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .p(mul_p),
    .busy(mul_busy), .done(mul_done)
  );

  esc_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d), .quotient(div_q),
    .busy(div_busy), .done(div_done)
  );

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;
  logic [63:0] adc, hadc, ft64, hx;
  logic [31:0] hclamp;

  assign t1 = {48'd0, coeffs.temp_coeffs[15:0]};
  assign t2 = sx16(coeffs.temp_coeffs[31:16]);
  assign t3 = sx16(coeffs.temp_coeffs[47:32]);
  assign p1 = {48'd0, coeffs.press_coeffs_a[15:0]};
  assign p2 = sx16(coeffs.press_coeffs_a[31:16]);
  assign p3 = sx16(coeffs.press_coeffs_a[47:32]);
  assign p4 = sx16(coeffs.press_coeffs_b[15:0]);
  assign p5 = sx16(coeffs.press_coeffs_b[31:16]);
  assign p6 = sx16(coeffs.press_coeffs_b[47:32]);
  assign p7 = sx16(coeffs.press_coeffs_c[15:0]);
  assign p8 = sx16(coeffs.press_coeffs_c[31:16]);
  assign p9 = sx16(coeffs.press_coeffs_c[47:32]);
  assign h1 = {56'd0, coeffs.hum_coeffs_a[7:0]};
  assign h2 = sx16(coeffs.hum_coeffs_a[23:8]);
  assign h3 = {56'd0, coeffs.hum_coeffs_a[31:24]};
  assign h4 = sx16({{4{coeffs.hum_coeffs_b[11]}}, coeffs.hum_coeffs_b[11:0]});
  assign h5 = sx16({{4{coeffs.hum_coeffs_b[23]}}, coeffs.hum_coeffs_b[23:12]});
  assign h6 = sx16({{8{coeffs.hum_coeffs_b[31]}}, coeffs.hum_coeffs_b[31:24]});

  assign adc  = {44'd0, raw};
  assign hadc = {48'd0, raw[15:0]};
  assign ft64 = sx32(fine_temperature);

  // Humidity final subtract and clamp
  assign hx = x - asr32(prod, 6'd4);
  always_comb begin
    if (hx[31]) begin
      hclamp = '0;
    end else if (hx[31:0] > HumClamp) begin
      hclamp = HumClamp;
    end else begin
      hclamp = hx[31:0];
    end
  end

  assign sample_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pc               <= '0;
      op               <= OP_TEMP;
      fine_temperature <= '0;
      mul_start        <= 1'b0;
      div_start        <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (state == S_FIN && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            op        <= sample.operation;
            raw       <= sample.raw_sample;
            pc        <= '0;
            res_value <= '0;
            res_bad   <= 1'b0;
            state     <= S_RUN;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            prod  <= mul_p;
            pc    <= pc + 4'd1;
            state <= S_RUN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            y     <= neg ? 64'd0 - div_q : div_q;
            pc    <= pc + 4'd1;
            state <= S_RUN;
          end
        end
        S_FIN: begin
          if (!result_valid || result_ready) begin
            result.compensated_value <= res_value;
            result.pressure_invalid  <= res_bad;
            state                    <= S_IDLE;
          end
        end
        S_RUN: begin
          // Default: issue a product and wait for it.
          state     <= S_MUL;
          mul_start <= 1'b1;
          case (op)
            OP_TEMP: begin
              case (pc)
                4'd0: begin
                  y     <= sx32(32'((adc >> 4) - t1));
                  mul_a <= sx32(32'((adc >> 3) - (t1 << 1)));
                  mul_b <= t2;
                end
                4'd1: begin
                  x     <= asr32(prod, 6'd11);
                  mul_a <= y;
                  mul_b <= y;
                end
                4'd2: begin
                  mul_a <= asr32(prod, 6'd12);
                  mul_b <= t3;
                end
                4'd3: begin
                  z                <= sx32(32'(x + asr32(prod, 6'd14)));
                  fine_temperature <= 32'(x + asr32(prod, 6'd14));
                  mul_start        <= 1'b0;
                  pc               <= pc + 4'd1;
                  state            <= S_RUN;
                end
                default: begin
                  res_value <= 33'(asr32((z << 2) + z + 64'd128, 6'd8));
                  mul_start <= 1'b0;
                  state     <= S_FIN;
                end
              endcase
            end
            OP_PRESS: begin
              case (pc)
                4'd0: begin
                  x     <= ft64 - 64'd128000;
                  mul_a <= ft64 - 64'd128000;
                  mul_b <= ft64 - 64'd128000;
                end
                4'd1: begin
                  y     <= prod;
                  mul_a <= prod;
                  mul_b <= p6;
                end
                4'd2: begin
                  z     <= prod;
                  mul_a <= x;
                  mul_b <= p5;
                end
                4'd3: begin
                  z     <= z + (prod << 17) + (p4 << 35);
                  mul_a <= y;
                  mul_b <= p3;
                end
                4'd4: begin
                  w     <= asr64(prod, 6'd8);
                  mul_a <= x;
                  mul_b <= p2;
                end
                4'd5: begin
                  mul_a <= (64'd1 << 47) + w + (prod << 12);
                  mul_b <= p1;
                end
                4'd6: begin
                  x <= asr64(prod, 6'd33);
                  if (asr64(prod, 6'd33) == 64'd0) begin
                    // Zero divisor: force the result and flag it.
                    res_bad   <= 1'b1;
                    mul_start <= 1'b0;
                    state     <= S_FIN;
                  end else begin
                    mul_a <= ((64'd1048576 - adc) << 31) - z;
                    mul_b <= 64'd3125;
                  end
                end
                4'd7: begin
                  neg       <= prod[63] ^ x[63];
                  div_n     <= prod[63] ? 64'd0 - prod : prod;
                  div_d     <= x[63] ? 64'd0 - x : x;
                  div_start <= 1'b1;
                  mul_start <= 1'b0;
                  state     <= S_DIV;
                end
                4'd8: begin
                  mul_a <= p9;
                  mul_b <= asr64(y, 6'd13);
                end
                4'd9: begin
                  mul_a <= prod;
                  mul_b <= asr64(y, 6'd13);
                end
                4'd10: begin
                  w     <= asr64(prod, 6'd25);
                  mul_a <= p8;
                  mul_b <= y;
                end
                default: begin
                  res_value <= 33'(asr64(y + w + asr64(prod, 6'd19), 6'd8) + (p7 << 4));
                  mul_start <= 1'b0;
                  state     <= S_FIN;
                end
              endcase
            end
            OP_HUM: begin
              case (pc)
                4'd0: begin
                  x     <= sx32(32'(ft64 - 64'd76800));
                  mul_a <= h5;
                  mul_b <= sx32(32'(ft64 - 64'd76800));
                end
                4'd1: begin
                  y     <= asr32((hadc << 14) - (h4 << 20) - prod + 64'd16384, 6'd15);
                  mul_a <= x;
                  mul_b <= h6;
                end
                4'd2: begin
                  z     <= asr32(prod, 6'd10);
                  mul_a <= x;
                  mul_b <= h3;
                end
                4'd3: begin
                  mul_a <= z;
                  mul_b <= asr32(prod, 6'd11) + 64'd32768;
                end
                4'd4: begin
                  mul_a <= asr32(prod, 6'd10) + 64'd2097152;
                  mul_b <= h2;
                end
                4'd5: begin
                  mul_a <= y;
                  mul_b <= asr32(prod + 64'd8192, 6'd14);
                end
                4'd6: begin
                  x     <= sx32(prod[31:0]);
                  mul_a <= asr32(prod, 6'd15);
                  mul_b <= asr32(prod, 6'd15);
                end
                4'd7: begin
                  mul_a <= asr32(prod, 6'd7);
                  mul_b <= h1;
                end
                default: begin
                  res_value <= {13'd0, hclamp[31:12]};
                  mul_start <= 1'b0;
                  state     <= S_FIN;
                end
              endcase
            end
            default: begin
              mul_start <= 1'b0;
              state     <= S_FIN;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while a transaction is in work");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pressure_invalid |-> result.compensated_value == 33'd0)
    else $error("flagged pressure result is not zero");

  a_ft_only_temp: assert property (@(posedge clk) disable iff (rst)
    !$stable(fine_temperature) |-> op == OP_TEMP)
    else $error("fine temperature changed outside a temperature transaction");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mul_busy && !div_busy)
    else $error("arithmetic unit busy while sequencer idle");

endmodule

FILE: src/esc_regs.sv
module esc_regs
  import esc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output coeffs_t              coeffs
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[AddrWidth-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeffs <= '0;
    end else if (wr) begin
      case (idx)
        REG_TEMP:    coeffs.temp_coeffs    <= pwdata[47:0];
        REG_PRESS_A: coeffs.press_coeffs_a <= pwdata[47:0];
        REG_PRESS_B: coeffs.press_coeffs_b <= pwdata[47:0];
        REG_PRESS_C: coeffs.press_coeffs_c <= pwdata[47:0];
        REG_HUM_A:   coeffs.hum_coeffs_a   <= pwdata[31:0];
        REG_HUM_B:   coeffs.hum_coeffs_b   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TEMP:    prdata = {16'd0, coeffs.temp_coeffs};
      REG_PRESS_A: prdata = {16'd0, coeffs.press_coeffs_a};
      REG_PRESS_B: prdata = {16'd0, coeffs.press_coeffs_b};
      REG_PRESS_C: prdata = {16'd0, coeffs.press_coeffs_c};
      REG_HUM_A:   prdata = {32'd0, coeffs.hum_coeffs_a};
      REG_HUM_B:   prdata = {32'd0, coeffs.hum_coeffs_b};
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: src/esc_mul.sv
module esc_mul
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        busy,
  output logic        done
);

  // Radix-16 shift-and-add, low 64 bits of the product.
  logic [63:0] a_sh;
  logic [63:0] b_sh;
  logic [3:0]  cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= a;
        b_sh <= b;
        p    <= '0;
      end else if (busy) begin
        p    <= p + 64'(a_sh * b_sh[3:0]);
        a_sh <= a_sh << 4;
        b_sh <= b_sh >> 4;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/esc_div.sv
module esc_div
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient,
  output logic        busy,
  output logic        done
);

  // Restoring division, one quotient bit per cycle.
  logic [64:0] rem;
  logic [63:0] dsr;
  logic [5:0]  cnt;
  logic [64:0] shifted;
  logic [64:0] diff;

  assign shifted = {rem[63:0], quotient[63]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
      end else if (busy) begin
        if (!diff[64]) begin
          rem      <= diff;
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem      <= shifted;
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import esc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic pready;

  env_sensor_compensation_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Calibration shadow and stored fine temperature
  logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
  logic [31:0] cal_ha, cal_hb;
  logic signed [31:0] t_fine;

  sample_t pending_samples[$];
  result_t expected_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int checked = 0;
  int invalid_seen = 0;
  longint cycles = 0;

  function automatic logic signed [31:0] sra32(logic signed [31:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic signed [63:0] sra64(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic result_t compensate(sample_t s);
    result_t r;
    logic signed [31:0] t1, t2, t3, a, b, v1s, v2s;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, v, c, d, e, x, y;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] w1, w2, pp, ps, ua, ub, q;
    logic [31:0] adc;
    r = '0;
    adc = {12'd0, s.raw_sample};
    case (s.operation)
      OP_TEMP: begin
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        a = (adc >> 3) - (t1 << 1);
        v1s = sra32(a * t2, 11);
        b = (adc >> 4) - t1;
        v2s = sra32(sra32(b * b, 12) * t3, 14);
        t_fine = v1s + v2s;
        v = sra32(t_fine * 5 + 128, 8);
        r.compensated_value = {v[31], v};
      end
      OP_PRESS: begin
        p1 = {48'd0, cal_pa[15:0]};
        p2 = {{48{cal_pa[31]}}, cal_pa[31:16]};
        p3 = {{48{cal_pa[47]}}, cal_pa[47:32]};
        p4 = {{48{cal_pb[15]}}, cal_pb[15:0]};
        p5 = {{48{cal_pb[31]}}, cal_pb[31:16]};
        p6 = {{48{cal_pb[47]}}, cal_pb[47:32]};
        p7 = {{48{cal_pc[15]}}, cal_pc[15:0]};
        p8 = {{48{cal_pc[31]}}, cal_pc[31:16]};
        p9 = {{48{cal_pc[47]}}, cal_pc[47:32]};
        w1 = 64'(t_fine) - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) << 17);
        w2 = w2 + (p4 << 35);
        w1 = sra64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = sra64(((64'sd1 << 47) + w1) * p1, 33);
        if (w1 == 0) begin
          r.pressure_invalid = 1'b1;
        end else begin
          pp = 64'sd1048576 - 64'(adc);
          pp = ((pp << 31) - w2) * 64'sd3125;
          // Truncating divide on magnitudes; min / -1 wraps naturally
          ua = pp[63] ? -pp : pp;
          ub = w1[63] ? -w1 : w1;
          q = 64'($unsigned(ua) / $unsigned(ub));
          pp = (pp[63] != w1[63]) ? -q : q;
          ps = sra64(pp, 13);
          w1 = sra64(p9 * ps * ps, 25);
          w2 = sra64(p8 * pp, 19);
          pp = sra64(pp + w1 + w2, 8) + (p7 << 4);
          r.compensated_value = pp[32:0];
        end
      end
      OP_HUM: begin
        h1 = {24'd0, cal_ha[7:0]};
        h2 = {{16{cal_ha[23]}}, cal_ha[23:8]};
        h3 = {24'd0, cal_ha[31:24]};
        h4 = {{20{cal_hb[11]}}, cal_hb[11:0]};
        h5 = {{20{cal_hb[23]}}, cal_hb[23:12]};
        h6 = {{24{cal_hb[31]}}, cal_hb[31:24]};
        adc = {16'd0, s.raw_sample[15:0]};
        v = t_fine - 32'sd76800;
        a = sra32((adc << 14) - (h4 << 20) - h5 * v + 16384, 15);
        b = sra32(v * h6, 10);
        c = sra32(v * h3, 11) + 32768;
        d = sra32(b * c, 10) + 2097152;
        e = sra32(d * h2 + 8192, 14);
        x = a * e;
        y = sra32(x, 15);
        y = sra32(sra32(y * y, 7) * h1, 4);
        x = x - y;
        if (x < 0) x = 0;
        else if (x > 32'sd419430400) x = 32'sd419430400;
        r.compensated_value = {13'd0, x[31:12]};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample_valid && !sample_ready) begin
      // hold
    end else if (pending_samples.size() > 0 &&
                 $urandom_range(99, 0) >= send_idle_pct) begin
      sample <= pending_samples[0];
      expected_results.push_back(compensate(pending_samples.pop_front()));
      sample_valid <= 1'b1;
    end else begin
      sample_valid <= 1'b0;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          errors++;
        end else begin
          checked++;
          if (result.compensated_value !== expected_results[0].compensated_value) begin
            $display("%0t: value mismatch expected %h actual %h", $time,
                     expected_results[0].compensated_value, result.compensated_value);
            errors++;
          end
          if (result.pressure_invalid !== expected_results[0].pressure_invalid) begin
            $display("%0t: invalid flag mismatch expected %b actual %b", $time,
                     expected_results[0].pressure_invalid, result.pressure_invalid);
            errors++;
          end
          if (result.pressure_invalid === 1'b1) invalid_seen++;
          void'(expected_results.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2_500_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic cal_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'({idx, 3'b000});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TEMP: cal_t = val[47:0];
      REG_PRESS_A: cal_pa = val[47:0];
      REG_PRESS_B: cal_pb = val[47:0];
      REG_PRESS_C: cal_pc = val[47:0];
      REG_HUM_A: cal_ha = val[31:0];
      REG_HUM_B: cal_hb = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [63:0] rand48();
    return {16'd0, 16'($urandom_range(65535, 0)), $urandom()};
  endfunction

  // Typical device calibration, so pressure paths yield meaningful numbers
  task automatic load_typical();
    cal_write(REG_TEMP,
              64'({16'hFFF6 ^ 16'($urandom_range(7, 0)), 16'd26435, 16'd27504}));
    cal_write(REG_PRESS_A,
              64'({-16'sd2987, -16'sd10685, 16'(36000 + $urandom_range(2000, 0))}));
    cal_write(REG_PRESS_B, 64'({-16'sd7, 16'sd140, 16'sd2855}));
    cal_write(REG_PRESS_C, 64'({16'sd6000, -16'sd7, 16'sd15500}));
    cal_write(REG_HUM_A, 64'({8'd0, 16'sd362, 8'd75}));
    cal_write(REG_HUM_B, 64'({8'sd30, 12'sd50, 12'sd313}));
  endtask

  function automatic sample_t pick_sample();
    sample_t s;
    int r;
    r = $urandom_range(99, 0);
    s.operation = (r < 30) ? OP_TEMP : (r < 65) ? OP_PRESS : (r < 95) ? OP_HUM : OP_RSVD;
    s.raw_sample = ($urandom_range(3, 0) == 0) ? 20'($urandom()) :
                   20'($urandom_range(600000, 300000));
    return s;
  endfunction

  initial begin
    sample_t s;
    int phase;
    cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_ha = '0; cal_hb = '0;
    t_fine = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Zero coefficients: pressure divisor is zero, flag must rise
    s.operation = OP_PRESS; s.raw_sample = 20'hFFFFF; pending_samples.push_back(s);
    s.operation = OP_HUM; s.raw_sample = 20'hFFFFF; pending_samples.push_back(s);
    s.operation = OP_TEMP; s.raw_sample = 20'h00000; pending_samples.push_back(s);
    s.operation = OP_RSVD; s.raw_sample = 20'hABCDE; pending_samples.push_back(s);
    drain();

    load_typical();
    s.operation = OP_TEMP; s.raw_sample = 20'd519888; pending_samples.push_back(s);
    s.operation = OP_PRESS; s.raw_sample = 20'd415148; pending_samples.push_back(s);
    s.operation = OP_HUM; s.raw_sample = 20'd30000; pending_samples.push_back(s);
    s.operation = OP_HUM; s.raw_sample = 20'hF0000; pending_samples.push_back(s);
    s.operation = OP_HUM; s.raw_sample = 20'h0FFFF; pending_samples.push_back(s);
    s.operation = OP_PRESS; s.raw_sample = 20'd0; pending_samples.push_back(s);
    s.operation = OP_PRESS; s.raw_sample = 20'hFFFFF; pending_samples.push_back(s);
    s.operation = OP_TEMP; s.raw_sample = 20'hFFFFF; pending_samples.push_back(s);
    s.operation = OP_HUM; s.raw_sample = 20'd0; pending_samples.push_back(s);
    s.operation = OP_TEMP; s.raw_sample = 20'h55555; pending_samples.push_back(s);
    s.operation = OP_PRESS; s.raw_sample = 20'hAAAAA; pending_samples.push_back(s);
    drain();

    // Extreme coefficients
    cal_write(REG_TEMP, 64'hFFFF_FFFF_FFFF);
    cal_write(REG_PRESS_A, 64'h8000_7FFF_FFFF);
    cal_write(REG_PRESS_B, 64'h7FFF_8000_7FFF);
    cal_write(REG_PRESS_C, 64'h8000_8000_8000);
    cal_write(REG_HUM_A, 64'hFF7F_FFFF);
    cal_write(REG_HUM_B, 64'h8080_0800);
    for (int i = 0; i < 8; i++) pending_samples.push_back(pick_sample());
    drain();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 14 : 0;
      for (int blk = 0; blk < 8; blk++) begin
        case ($urandom_range(3, 0))
          0: begin
            cal_write(REG_TEMP, rand48()); cal_write(REG_PRESS_A, rand48());
            cal_write(REG_PRESS_B, rand48()); cal_write(REG_PRESS_C, rand48());
            cal_write(REG_HUM_A, 64'($urandom())); cal_write(REG_HUM_B, 64'($urandom()));
          end
          default: load_typical();
        endcase
        if (blk == 3) hold_cycles = 2000;
        for (int i = 0; i < 47; i++) pending_samples.push_back(pick_sample());
        drain();
      end
    end

    $display("checked %0d results across temperature, pressure, humidity and unknown",
             checked);
    $display("zero-divisor pressure results: %0d", invalid_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: env_sensor_compensation_unit.f
src/esc_pkg.sv
src/esc_regs.sv
src/esc_mul.sv
src/esc_div.sv
src/env_sensor_compensation_unit.sv
tb/tb.sv
